// ===== hw/rtl/vat_pkg.sv =====
`default_nettype none

package vat_pkg;

    localparam int LANE_W    = 16;
    localparam int COORD_W   = 16;
    localparam int FRAC_BITS = 14;
    localparam int REG_W     = 3 * LANE_W;
    localparam int PROD_W    = LANE_W + COORD_W;
    localparam int ACC_W     = ((PROD_W > LANE_W + FRAC_BITS) ? PROD_W : LANE_W + FRAC_BITS) + 2;
    localparam int IDX_W     = 3;
    localparam int QDEPTH    = 2;

    localparam logic [IDX_W-1:0] REG_ROT_X       = 3'd0;
    localparam logic [IDX_W-1:0] REG_ROT_Y       = 3'd1;
    localparam logic [IDX_W-1:0] REG_ROT_Z       = 3'd2;
    localparam logic [IDX_W-1:0] REG_TRANSLATION = 3'd3;
    localparam logic [IDX_W-1:0] REG_USE_NORMALS = 3'd4;

    typedef logic signed [LANE_W-1:0]  lane_t;
    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [ACC_W-1:0]   acc_t;

    typedef struct packed {
        logic [REG_W-1:0] rot_x;
        logic [REG_W-1:0] rot_y;
        logic [REG_W-1:0] rot_z;
        logic [REG_W-1:0] trans;
        logic             use_normals;
    } cfg_t;

    // products of one vertex, row-major: prod[row][col]
    typedef struct packed {
        logic                     first;
        logic [2:0][2:0][PROD_W-1:0] pprod;
        logic [2:0][2:0][PROD_W-1:0] nprod;
        logic [2:0][COORD_W-1:0]  nraw;
    } item_t;

    localparam acc_t HALF   = acc_t'(1) <<< (FRAC_BITS - 1);
    localparam acc_t SAT_HI = {{(ACC_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
    localparam acc_t SAT_LO = ~SAT_HI;

    function automatic lane_t get_lane(input logic [REG_W-1:0] r, input int k);
        return lane_t'(r[k*LANE_W +: LANE_W]);
    endfunction

    // round half up, then clamp to the coordinate range
    function automatic coord_t round_sat(input acc_t acc);
        acc_t r;
        r = (acc + HALF) >>> FRAC_BITS;
        if (r > SAT_HI)
            return coord_t'(SAT_HI[COORD_W-1:0]);
        else if (r < SAT_LO)
            return coord_t'(SAT_LO[COORD_W-1:0]);
        return coord_t'(r[COORD_W-1:0]);
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/vat_front.sv =====
`default_nettype none

module vat_front (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire vat_pkg::cfg_t           cfg,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire logic                    first_of_set,
    input  wire vat_pkg::coord_t [2:0]   pos,
    input  wire vat_pkg::coord_t [2:0]   nrm,
    input  wire logic                    q_full,
    output logic                         f_push,
    output vat_pkg::item_t               f_item
);
    import vat_pkg::*;

    logic [REG_W-1:0] rows [3];
    logic             f_valid_reg, f_valid_next;
    item_t            f_item_reg, f_item_next;
    logic             load;

    assign rows[0] = cfg.rot_x;
    assign rows[1] = cfg.rot_y;
    assign rows[2] = cfg.rot_z;

    always_comb
    begin
        f_item_next.first = first_of_set;
        for (int i = 0; i < 3; i++)
        begin
            f_item_next.nraw[i] = nrm[i];
            for (int j = 0; j < 3; j++)
            begin
                f_item_next.pprod[i][j] = PROD_W'($signed(get_lane(rows[i], j)) * $signed(pos[j]));
                f_item_next.nprod[i][j] = PROD_W'($signed(get_lane(rows[i], j)) * $signed(nrm[j]));
            end
        end
    end

    assign in_stall = f_valid_reg && q_full;
    assign load     = in_valid && !in_stall;
    assign f_push   = f_valid_reg && !q_full;
    assign f_item   = f_item_reg;

    always_comb
    begin
        priority if (load)
            f_valid_next = 1'b1;
        else if (f_push)
            f_valid_next = 1'b0;
        else
            f_valid_next = f_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f_valid_reg <= 1'b0;
        else
            f_valid_reg <= f_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            f_item_reg <= f_item_next;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/vat_queue.sv =====
`default_nettype none

module vat_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire vat_pkg::item_t push_item,
    output logic                full,
    input  wire logic           pop,
    output logic                q_valid,
    output vat_pkg::item_t      head_item
);
    import vat_pkg::*;

    localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNT_W = $clog2(QDEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(QDEPTH - 1);

    item_t            mem_reg [QDEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full      = (count_reg == CNT_W'(QDEPTH));
    assign q_valid   = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && q_valid;
    assign head_item = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/vat_back.sv =====
`default_nettype none

module vat_back (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire vat_pkg::cfg_t         cfg,
    input  wire logic                  q_valid,
    input  wire vat_pkg::item_t        q_item,
    output logic                       q_pop,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output vat_pkg::coord_t [2:0]      out_pos,
    output vat_pkg::coord_t [2:0]      out_nrm,
    output vat_pkg::coord_t [2:0]      box_hi,
    output vat_pkg::coord_t [2:0]      box_lo
);
    import vat_pkg::*;

    // stage A: sum, round, saturate
    logic             a_valid_reg, a_valid_next;
    logic             a_first_reg;
    coord_t [2:0]     a_tp_reg, a_tp_next;
    coord_t [2:0]     a_tn_reg, a_tn_next;
    acc_t   [2:0]     psum, nsum;
    logic             a_ready, a_load;

    // stage B: box update and output register
    logic             out_valid_reg, out_valid_next;
    coord_t [2:0]     out_pos_reg, out_nrm_reg;
    coord_t [2:0]     box_hi_reg, box_hi_next;
    coord_t [2:0]     box_lo_reg, box_lo_next;
    logic             b_ready, b_load;

    assign b_ready = !out_valid_reg || !out_stall;
    assign a_ready = !a_valid_reg || b_ready;
    assign q_pop   = a_ready;
    assign a_load  = q_valid && a_ready;
    assign b_load  = a_valid_reg && b_ready;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            psum[i] = acc_t'($signed(q_item.pprod[i][0])) + acc_t'($signed(q_item.pprod[i][1]))
                    + acc_t'($signed(q_item.pprod[i][2]))
                    + (acc_t'(get_lane(cfg.trans, i)) <<< FRAC_BITS);
            nsum[i] = acc_t'($signed(q_item.nprod[i][0])) + acc_t'($signed(q_item.nprod[i][1]))
                    + acc_t'($signed(q_item.nprod[i][2]));
            a_tp_next[i] = round_sat(psum[i]);
            a_tn_next[i] = cfg.use_normals ? round_sat(nsum[i]) : coord_t'(q_item.nraw[i]);
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (a_first_reg)
            begin
                box_hi_next[i] = a_tp_reg[i];
                box_lo_next[i] = a_tp_reg[i];
            end
            else
            begin
                box_hi_next[i] = ($signed(a_tp_reg[i]) > $signed(box_hi_reg[i])) ?
                                 a_tp_reg[i] : box_hi_reg[i];
                box_lo_next[i] = ($signed(a_tp_reg[i]) < $signed(box_lo_reg[i])) ?
                                 a_tp_reg[i] : box_lo_reg[i];
            end
        end
    end

    always_comb
    begin
        priority if (a_load)
            a_valid_next = 1'b1;
        else if (b_load)
            a_valid_next = 1'b0;
        else
            a_valid_next = a_valid_reg;

        priority if (b_load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            box_hi_reg    <= '0;
            box_lo_reg    <= '0;
        end
        else
        begin
            a_valid_reg   <= a_valid_next;
            out_valid_reg <= out_valid_next;
            if (b_load)
            begin
                box_hi_reg <= box_hi_next;
                box_lo_reg <= box_lo_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_load)
        begin
            a_first_reg <= q_item.first;
            a_tp_reg    <= a_tp_next;
            a_tn_reg    <= a_tn_next;
        end
        if (b_load)
        begin
            out_pos_reg <= a_tp_reg;
            out_nrm_reg <= a_tn_reg;
        end
    end

    // the box registers always hold the box after the vertex on display
    assign out_valid = out_valid_reg;
    assign out_pos   = out_pos_reg;
    assign out_nrm   = out_nrm_reg;
    assign box_hi    = box_hi_reg;
    assign box_lo    = box_lo_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/vertex_affine_transform_bbox.sv =====
`default_nettype none

// Affine vertex transform with running bounding box. Each transfer on the
// input side carries one vertex (Q8.8 position and normal); the block rotates
// it by the configured Q2.14 matrix, adds the Q8.8 translation to the
// position (the normal is rotated only, or passed through when use_normals is
// 0), rounds half up, saturates to 16 bits and updates the axis-aligned box,
// which restarts on a vertex flagged first_of_set. One result per vertex, in
// order. Throughput is one vertex per cycle while out_stall is low, through a
// multiply stage in the front end, a two-entry queue, a sum/round stage and
// the box-update stage whose min/max loop sets the rate. Configuration
// registers (index 0..4: rotation rows x, y, z, translation, use_normals; other
// indexes are ignored) are written through cfg_wen; the user must write them
// only while no vertex is in flight, which the block itself does not enforce.
module vertex_affine_transform_bbox (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_wen,
    input  wire logic [vat_pkg::IDX_W-1:0]       cfg_index,
    input  wire logic [vat_pkg::REG_W-1:0]       cfg_wdata,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic                            first_of_set,
    input  wire vat_pkg::coord_t                 pos_x,
    input  wire vat_pkg::coord_t                 pos_y,
    input  wire vat_pkg::coord_t                 pos_z,
    input  wire vat_pkg::coord_t                 norm_x,
    input  wire vat_pkg::coord_t                 norm_y,
    input  wire vat_pkg::coord_t                 norm_z,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output vat_pkg::coord_t                      out_x,
    output vat_pkg::coord_t                      out_y,
    output vat_pkg::coord_t                      out_z,
    output vat_pkg::coord_t                      out_nx,
    output vat_pkg::coord_t                      out_ny,
    output vat_pkg::coord_t                      out_nz,
    output vat_pkg::coord_t                      max_x,
    output vat_pkg::coord_t                      min_x,
    output vat_pkg::coord_t                      max_y,
    output vat_pkg::coord_t                      min_y,
    output vat_pkg::coord_t                      max_z,
    output vat_pkg::coord_t                      min_z
);
    import vat_pkg::*;

    localparam logic [REG_W-1:0] ONE = REG_W'(1) << FRAC_BITS;

    cfg_t          cfg_reg;
    coord_t [2:0]  pos, nrm;
    coord_t [2:0]  out_pos, out_nrm, box_hi, box_lo;
    item_t         f_item, q_head;
    logic          f_push, q_full, q_valid, q_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rot_x       <= ONE;
            cfg_reg.rot_y       <= ONE << LANE_W;
            cfg_reg.rot_z       <= ONE << (2 * LANE_W);
            cfg_reg.trans       <= '0;
            cfg_reg.use_normals <= 1'b1;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                REG_ROT_X:       cfg_reg.rot_x       <= cfg_wdata;
                REG_ROT_Y:       cfg_reg.rot_y       <= cfg_wdata;
                REG_ROT_Z:       cfg_reg.rot_z       <= cfg_wdata;
                REG_TRANSLATION: cfg_reg.trans       <= cfg_wdata;
                REG_USE_NORMALS: cfg_reg.use_normals <= cfg_wdata[0];
                default:         ;
            endcase
        end
    end

    assign pos = {pos_z, pos_y, pos_x};
    assign nrm = {norm_z, norm_y, norm_x};

    vat_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .first_of_set (first_of_set),
        .pos          (pos),
        .nrm          (nrm),
        .q_full       (q_full),
        .f_push       (f_push),
        .f_item       (f_item)
    );

    vat_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (f_push),
        .push_item (f_item),
        .full      (q_full),
        .pop       (q_pop),
        .q_valid   (q_valid),
        .head_item (q_head)
    );

    vat_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_item    (q_head),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_pos   (out_pos),
        .out_nrm   (out_nrm),
        .box_hi    (box_hi),
        .box_lo    (box_lo)
    );

    assign out_x  = out_pos[0];
    assign out_y  = out_pos[1];
    assign out_z  = out_pos[2];
    assign out_nx = out_nrm[0];
    assign out_ny = out_nrm[1];
    assign out_nz = out_nrm[2];
    assign max_x  = box_hi[0];
    assign min_x  = box_lo[0];
    assign max_y  = box_hi[1];
    assign min_y  = box_lo[1];
    assign max_z  = box_hi[2];
    assign min_z  = box_lo[2];

endmodule

`default_nettype wire

// ===== hw/rtl/vat_checker.sv =====
`default_nettype none

module vat_props (
    input wire logic            clk,
    input wire logic            rst_n,
    input wire logic            in_valid,
    input wire logic            in_stall,
    input wire logic            out_valid,
    input wire logic            out_stall,
    input wire vat_pkg::coord_t out_x,
    input wire vat_pkg::coord_t out_y,
    input wire vat_pkg::coord_t out_z,
    input wire vat_pkg::coord_t out_nx,
    input wire vat_pkg::coord_t out_ny,
    input wire vat_pkg::coord_t out_nz,
    input wire vat_pkg::coord_t max_x,
    input wire vat_pkg::coord_t min_x,
    input wire vat_pkg::coord_t max_y,
    input wire vat_pkg::coord_t min_y,
    input wire vat_pkg::coord_t max_z,
    input wire vat_pkg::coord_t min_z
);
    // front stage, two queue entries, sum stage, output stage
    localparam logic [3:0] CAPACITY = 4'd5;

    logic [3:0] pending_reg, pending_next;
    logic       in_xfer, out_xfer;

    assign in_xfer  = in_valid && !in_stall;
    assign out_xfer = out_valid && !out_stall;

    always_comb
    begin
        unique case ({in_xfer, out_xfer})
            2'b10:   pending_next = pending_reg + 1'b1;
            2'b01:   pending_next = pending_reg - 1'b1;
            default: pending_next = pending_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= '0;
        else
            pending_reg <= pending_next;
    end

    // hold the result while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid
            && $stable({out_x, out_y, out_z, out_nx, out_ny, out_nz,
                        max_x, min_x, max_y, min_y, max_z, min_z}))
        else $error("result changed while stalled");

    a_box_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ($signed(min_x) <= $signed(max_x)) && ($signed(min_y) <= $signed(max_y))
            && ($signed(min_z) <= $signed(max_z)))
        else $error("box lower bound above upper bound");

    a_vertex_in_box: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ($signed(out_x) >= $signed(min_x)) && ($signed(out_x) <= $signed(max_x))
            && ($signed(out_y) >= $signed(min_y)) && ($signed(out_y) <= $signed(max_y))
            && ($signed(out_z) >= $signed(min_z)) && ($signed(out_z) <= $signed(max_z)))
        else $error("vertex outside its own box");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 4'd0)
        else $error("result without a pending vertex");

    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= CAPACITY)
        else $error("more vertices in flight than the pipeline holds");

endmodule

bind vertex_affine_transform_bbox vat_props u_vat_props (.*);

`default_nettype wire
